/* rtl/core/prcde_pkg.sv */
// shared types and constants of the pixel run cache diff encoder
package prcde_pkg;

    localparam int HIST_DEPTH  = 64;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int ENTRY_BYTES = 5;
    localparam int CNT_W       = 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [5:0] RUN_LIMIT     = 6'd62;
    localparam logic [1:0] TAG_INDEX     = 2'b00;
    localparam logic [1:0] TAG_DIFF      = 2'b01;
    localparam logic [1:0] TAG_LUMA      = 2'b10;
    localparam logic [1:0] TAG_RUN       = 2'b11;
    localparam logic [7:0] RGB_TAG_RESET = 8'd254;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
        logic       end_of_image;
    } t_code_out;

    typedef struct packed {
        logic [ENTRY_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        last;
    } t_entry;

    function automatic logic [HIST_AW-1:0] hist_hash(input logic [23:0] c);
        logic [10:0] sum;
        sum = 11'd3 * {3'd0, c[23:16]} + 11'd5 * {3'd0, c[15:8]} + 11'd7 * {3'd0, c[7:0]};
        return sum[HIST_AW-1:0];
    endfunction

endpackage

/* rtl/core/prcde_front.sv */
// front end: pixel accept, run tracking, color history and code selection
module prcde_front
    import prcde_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_pixel_in i_pixel,
    output logic      o_full,
    input  logic [7:0] i_rgb_tag,
    output logic      o_q_push,
    output t_entry    o_entry,
    input  logic      i_q_full
);

    typedef struct packed {
        logic [23:0]        pix;
        logic [23:0]        prev;
        logic               eq;
        logic               lead_v;
        logic [7:0]         lead;
        logic               tail_v;
        logic [7:0]         tail;
        logic               last;
        logic [HIST_AW-1:0] hash;
    } t_stage;

    logic [23:0]           r_prev;
    logic [5:0]            r_run;
    logic [HIST_AW-1:0]    r_ptr;
    logic [HIST_DEPTH-1:0] r_hist_valid;
    logic [23:0]           r_hist_mem [HIST_DEPTH];
    logic [23:0]           r_hist_rd;
    logic                  r_hist_rd_v;
    logic                  r_b_valid;
    t_stage                r_b;

    logic               accept;
    logic [23:0]        cur;
    logic [HIST_AW-1:0] hash;
    logic [HIST_AW-1:0] ptr_inc;
    logic [5:0]         run_inc;
    logic [5:0]         run_mid;
    logic               eq;
    logic               lead_v;
    logic [7:0]         lead;
    logic               tail_v;
    logic [7:0]         tail;
    logic               b_done;
    logic               b_free;

    logic                    hit;
    logic signed [8:0]       dr;
    logic signed [8:0]       dg;
    logic signed [8:0]       db;
    logic signed [9:0]       drg;
    logic signed [9:0]       dbg;
    logic [8:0]              dr2;
    logic [8:0]              dg2;
    logic [8:0]              db2;
    logic [8:0]              dg32;
    logic [9:0]              drg8;
    logic [9:0]              dbg8;
    logic                    is_diff;
    logic                    is_luma;
    logic [3:0][7:0]         code;
    logic [CNT_W-1:0]        code_cnt;
    t_entry                  entry;

    assign cur     = {i_pixel.red, i_pixel.green, i_pixel.blue};
    assign hash    = hist_hash(cur);
    assign ptr_inc = r_ptr + HIST_AW'(1);
    assign run_inc = r_run + 6'd1;
    assign eq      = (cur == r_prev);

    assign b_done = r_b_valid && ((entry.count == '0) || !i_q_full);
    assign b_free = !r_b_valid || b_done;
    assign o_full = !b_free;
    assign accept = i_push && b_free;

    always_comb begin
        lead_v  = 1'b0;
        lead    = {TAG_RUN, r_run - 6'd1};
        run_mid = '0;
        if (eq) begin
            if (run_inc == RUN_LIMIT) begin
                lead_v = 1'b1;
                lead   = {TAG_RUN, run_inc - 6'd1};
            end else begin
                run_mid = run_inc;
            end
        end else if (r_run != '0) begin
            lead_v = 1'b1;
        end
        tail_v = i_pixel.last_pixel && (run_mid != '0);
        tail   = {TAG_RUN, run_mid - 6'd1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_run        <= '0;
            r_ptr        <= '0;
            r_hist_valid <= '0;
            r_b_valid    <= 1'b0;
        end else begin
            if (b_free) begin
                r_b_valid <= accept;
            end
            if (accept) begin
                if (i_pixel.last_pixel) begin
                    r_prev       <= '0;
                    r_run        <= '0;
                    r_ptr        <= '0;
                    r_hist_valid <= '0;
                end else begin
                    r_prev                <= cur;
                    r_run                 <= run_mid;
                    r_ptr                 <= ptr_inc;
                    r_hist_valid[ptr_inc] <= 1'b1;
                end
            end
        end
    end

    // history store, read before write at the same edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hist_mem[ptr_inc] <= cur;
            r_hist_rd           <= r_hist_mem[hash];
            r_hist_rd_v         <= r_hist_valid[hash];
            r_b.pix             <= cur;
            r_b.prev            <= r_prev;
            r_b.eq              <= eq;
            r_b.lead_v          <= lead_v;
            r_b.lead            <= lead;
            r_b.tail_v          <= tail_v;
            r_b.tail            <= tail;
            r_b.last            <= i_pixel.last_pixel;
            r_b.hash            <= hash;
        end
    end

    // code selection
    assign hit  = r_hist_rd_v ? (r_hist_rd == r_b.pix) : (r_b.pix == '0);
    assign dr   = $signed({1'b0, r_b.pix[23:16]}) - $signed({1'b0, r_b.prev[23:16]});
    assign dg   = $signed({1'b0, r_b.pix[15:8]}) - $signed({1'b0, r_b.prev[15:8]});
    assign db   = $signed({1'b0, r_b.pix[7:0]}) - $signed({1'b0, r_b.prev[7:0]});
    assign drg  = $signed({dr[8], dr}) - $signed({dg[8], dg});
    assign dbg  = $signed({db[8], db}) - $signed({dg[8], dg});
    assign dr2  = dr + 9'sd2;
    assign dg2  = dg + 9'sd2;
    assign db2  = db + 9'sd2;
    assign dg32 = dg + 9'sd32;
    assign drg8 = drg + 10'sd8;
    assign dbg8 = dbg + 10'sd8;

    assign is_diff = (dr >= -9'sd2) && (dr <= 9'sd1) && (dg >= -9'sd2) && (dg <= 9'sd1)
                  && (db >= -9'sd2) && (db <= 9'sd1);
    assign is_luma = (dg >= -9'sd32) && (dg <= 9'sd31) && (drg >= -10'sd8) && (drg <= 10'sd7)
                  && (dbg >= -10'sd8) && (dbg <= 10'sd7);

    always_comb begin
        code     = '0;
        code_cnt = '0;
        if (r_b.eq) begin
            code_cnt = '0;
        end else if (hit) begin
            code[0]  = {TAG_INDEX, r_b.hash};
            code_cnt = CNT_W'(1);
        end else if (is_diff) begin
            code[0]  = {TAG_DIFF, dr2[1:0], dg2[1:0], db2[1:0]};
            code_cnt = CNT_W'(1);
        end else if (is_luma) begin
            code[0]  = {TAG_LUMA, dg32[5:0]};
            code[1]  = {drg8[3:0], dbg8[3:0]};
            code_cnt = CNT_W'(2);
        end else begin
            code[0]  = i_rgb_tag;
            code[1]  = r_b.pix[23:16];
            code[2]  = r_b.pix[15:8];
            code[3]  = r_b.pix[7:0];
            code_cnt = CNT_W'(4);
        end
    end

    always_comb begin
        entry       = '0;
        entry.last  = r_b.last;
        if (r_b.tail_v) begin
            entry.bytes[0] = r_b.tail;
            entry.count    = CNT_W'(1);
        end else if (r_b.lead_v) begin
            entry.bytes[0] = r_b.lead;
            entry.bytes[1] = code[0];
            entry.bytes[2] = code[1];
            entry.bytes[3] = code[2];
            entry.bytes[4] = code[3];
            entry.count    = code_cnt + CNT_W'(1);
        end else begin
            entry.bytes[0] = code[0];
            entry.bytes[1] = code[1];
            entry.bytes[2] = code[2];
            entry.bytes[3] = code[3];
            entry.count    = code_cnt;
        end
    end

    assign o_entry  = entry;
    assign o_q_push = r_b_valid && (entry.count != '0) && !i_q_full;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_pixel.last_pixel |=> (r_ptr == '0) && (r_run == '0) && (r_prev == '0)
            && (r_hist_valid == '0))
        else $error("state not cleared after last pixel");
    a_last_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b.last |-> (entry.count != '0))
        else $error("last pixel produced no bytes");
    a_tail_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b.tail_v |-> r_b.eq && !r_b.lead_v)
        else $error("run flush at end mixed with other codes");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !b_done |=> r_b_valid && $stable(r_b))
        else $error("stalled code stage lost its beat");
`endif

endmodule

/* rtl/core/prcde_fifo.sv */
// small queue of coded pixels between front end and serializer
module prcde_fifo
    import prcde_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* rtl/core/prcde_serializer.sv */
// byte serializer: walks the bytes of the oldest queued code
module prcde_serializer
    import prcde_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_entry,
    input  logic      i_q_empty,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_code_out o_code
);

    logic [CNT_W-1:0] r_idx;
    logic             last_byte;
    logic             take;

    assign last_byte = (r_idx == i_entry.count - CNT_W'(1));
    assign o_empty   = i_q_empty;
    assign take      = i_pop && !i_q_empty;
    assign o_q_pop   = take && last_byte;

    assign o_code.out_byte     = i_entry.bytes[r_idx];
    assign o_code.last_of_item = last_byte;
    assign o_code.end_of_image = last_byte && i_entry.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= last_byte ? '0 : r_idx + CNT_W'(1);
        end
    end

endmodule

/* rtl/core/pixel_run_cache_diff_encoder.sv */
// top level of the pixel run cache diff encoder
//
// pixels enter as one beat each on i_pixel (red, green, blue, last_pixel),
// taken at an edge with push high and full low. coded bytes leave as one
// beat each on o_code (out_byte, last_of_item, end_of_image); the oldest
// byte is shown while empty is low and taken at an edge with pop high.
// the literal tag byte is written through i_cfg_we / i_cfg_data; the user
// must write it only while idle; the block does not enforce it. a pixel is
// taken every cycle while the code stage can move on; a pixel yields zero
// to five bytes and the output side moves one byte per cycle while pop is
// high, so bytes per pixel bound the sustained pixel rate. each code is
// chosen from the history read in the code stage, then queued; a four-entry
// code queue lets pixels keep coming while bytes wait. when the receiver
// stalls, bytes hold, the queue fills, and full rises.
// reset returns history, run, previous color and tag to their start values;
// the history is cleared at once, and again after each last pixel.
module pixel_run_cache_diff_encoder
    import prcde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  t_pixel_in  i_pixel,
    output logic       full,
    output logic       empty,
    input  logic       pop,
    output t_code_out  o_code,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_rgb_tag;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    t_entry     q_in;
    t_entry     q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgb_tag <= RGB_TAG_RESET;
        end else if (i_cfg_we) begin
            r_rgb_tag <= i_cfg_data;
        end
    end

    prcde_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pixel   (i_pixel),
        .o_full    (full),
        .i_rgb_tag (r_rgb_tag),
        .o_q_push  (q_push),
        .o_entry   (q_in),
        .i_q_full  (q_full)
    );

    prcde_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_empty (q_empty)
    );

    prcde_serializer u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_code    (o_code)
    );

endmodule
